// ===== rtl/core/haversine_distance_radius_bins_unit_defines.svh =====
// Assertion macros shared by the haversine unit RTL.
`ifndef HAVERSINE_DISTANCE_RADIUS_BINS_UNIT_DEFINES_SVH
`define HAVERSINE_DISTANCE_RADIUS_BINS_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HDR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define HDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hdr_pkg.sv =====
`default_nettype none
package hdr_pkg;
	localparam int CordicStagesDef = 20;
	localparam int NumLimits = 6;
	localparam int LimW = 22;
	localparam int AngW = 33;  // degrees Q17 span
	localparam int CW = 34;    // CORDIC datapath
	localparam int ZW = 33;
	localparam logic [LimW-1:0] LimitRst [NumLimits] =
		'{22'd1280, 22'd2560, 22'd3840, 22'd5120, 22'd6400, 22'd12800};
	localparam logic signed [AngW+1:0] DegFull = 35'sd47185920;
	localparam logic signed [AngW+1:0] DegHalf = 35'sd23592960;
	localparam logic signed [AngW+1:0] DegQuarter = 35'sd11796480;
	localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [CW-1:0] OneQ30 = 34'sd1073741824;
	localparam logic signed [CW-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam logic [22:0] DistMax = 23'd3181568;
	localparam int QDepth = 4;

	function automatic logic signed [CW-1:0] atan_tab(input int i);
		logic signed [CW-1:0] t;
		case (i)
			0: t = 34'sd843314857;
			1: t = 34'sd497837829;
			2: t = 34'sd263043837;
			3: t = 34'sd133525159;
			4: t = 34'sd67021687;
			5: t = 34'sd33543516;
			6: t = 34'sd16775851;
			7: t = 34'sd8388437;
			8: t = 34'sd4194283;
			9: t = 34'sd2097149;
			default: t = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
		endcase
		return t;
	endfunction

	typedef struct packed {
		logic signed [AngW-1:0] ang0;
		logic signed [AngW-1:0] ang1;
		logic signed [AngW-1:0] ang2;
		logic signed [AngW-1:0] ang3;
	} angles_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/hdr_front.sv =====
`default_nettype none
// Front end: registers a point pair and forms the four CORDIC angles (Q17 degrees).
module hdr_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic signed [23:0] lat1,
	input  wire logic signed [24:0] lon1,
	input  wire logic signed [23:0] lat2,
	input  wire logic signed [24:0] lon2,
	output logic out_valid,
	output hdr_pkg::angles_t out_ang
);
	hdr_pkg::angles_t ang_d;
	always_comb begin
		ang_d.ang0 = hdr_pkg::AngW'(lat2) - hdr_pkg::AngW'(lat1);
		ang_d.ang1 = hdr_pkg::AngW'(lon2) - hdr_pkg::AngW'(lon1);
		ang_d.ang2 = hdr_pkg::AngW'(lat1) <<< 1;
		ang_d.ang3 = hdr_pkg::AngW'(lat2) <<< 1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		out_ang <= ang_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/hdr_queue.sv =====
`default_nettype none
`include "haversine_distance_radius_bins_unit_defines.svh"
// Small FIFO between front and back; back pulls one beat per cycle.
module hdr_queue #(
	parameter int W = 8,
	parameter int D = hdr_pkg::QDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  hdr_pkg::q_ctl_t ctl,
	input  wire logic [W-1:0] wdata,
	output logic [W-1:0] rdata,
	output logic empty,
	output logic full
);
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;
	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (AW+1)'(D));
	assign do_push = ctl.push && (!full || ctl.pop);
	assign do_pop = ctl.pop && !empty;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == AW'(D-1)) ? '0 : wp_q + 1'b1;
			if (do_pop) rp_q <= (rp_q == AW'(D-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end
	`HDR_ASSERT_IMP(a_no_overflow, clk, arst_n, full && !ctl.pop, !ctl.push, "queue overflow")
	`HDR_ASSERT_NXT(a_cnt_up, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "count")
	`HDR_ASSERT_IMP(a_pop_ne, clk, arst_n, empty, !do_pop, "pop on empty")
endmodule
`default_nettype wire

// ===== rtl/core/hdr_back.sv =====
`default_nettype none
`include "haversine_distance_radius_bins_unit_defines.svh"
// Back end: pipelined CORDICs, products, roots, atan2, scale and bin compare.
module hdr_back #(
	parameter int CORDIC_STAGES = hdr_pkg::CordicStagesDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  hdr_pkg::angles_t in_ang,
	input  wire logic [hdr_pkg::LimW-1:0] limits [hdr_pkg::NumLimits],
	output logic out_valid,
	output logic [21:0] out_dist,
	output logic [5:0] out_mask
);
	localparam int CW = hdr_pkg::CW;
	localparam int N = 4;
	localparam int NS = CORDIC_STAGES;

	// ---- stage A: range reduction and degree->radian
	logic v_a;
	logic signed [CW-1:0] z_a [N];
	logic neg_a [N];
	logic signed [hdr_pkg::AngW+1:0] red [N];
	logic signed [hdr_pkg::AngW+1:0] fold [N];
	logic fneg [N];
	logic signed [hdr_pkg::AngW+1:0] angs [N];
	logic signed [63:0] prod [N];
	always_comb begin
		angs[0] = 35'(in_ang.ang0);
		angs[1] = 35'(in_ang.ang1);
		angs[2] = 35'(in_ang.ang2);
		angs[3] = 35'(in_ang.ang3);
		for (int k = 0; k < N; k++) begin
			red[k] = angs[k];
			if (red[k] >= hdr_pkg::DegFull) red[k] = red[k] - hdr_pkg::DegFull;
			else if (red[k] <= -hdr_pkg::DegFull) red[k] = red[k] + hdr_pkg::DegFull;
			if (red[k] > hdr_pkg::DegHalf) red[k] = red[k] - hdr_pkg::DegFull;
			else if (red[k] <= -hdr_pkg::DegHalf) red[k] = red[k] + hdr_pkg::DegFull;
			fneg[k] = 1'b0;
			fold[k] = red[k];
			if (red[k] > hdr_pkg::DegQuarter) begin
				fold[k] = hdr_pkg::DegHalf - red[k];
				fneg[k] = 1'b1;
			end else if (red[k] < -hdr_pkg::DegQuarter) begin
				fold[k] = -hdr_pkg::DegHalf - red[k];
				fneg[k] = 1'b1;
			end
			prod[k] = 64'(fold[k]) * 64'sd74961321 + 64'sd262144;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_a <= 1'b0;
		else v_a <= in_valid;
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			z_a[k] <= CW'(prod[k] >>> 19);
			neg_a[k] <= fneg[k];
		end
	end

	// ---- rotation CORDIC pipelines, one stage per iteration
	logic signed [CW-1:0] rx [NS+1][N];
	logic signed [CW-1:0] ry [NS+1][N];
	logic signed [CW-1:0] rz [NS+1][N];
	logic rn [NS+1][N];
	logic rv [NS+1];
	always_comb begin
		rv[0] = v_a;
		for (int k = 0; k < N; k++) begin
			rx[0][k] = hdr_pkg::CordicGain;
			ry[0][k] = '0;
			rz[0][k] = z_a[k];
			rn[0][k] = neg_a[k];
		end
	end
	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[i+1] <= 1'b0;
			else rv[i+1] <= rv[i];
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < N; k++) begin
				rn[i+1][k] <= rn[i][k];
				if (!rz[i][k][CW-1]) begin
					rx[i+1][k] <= rx[i][k] - (ry[i][k] >>> i);
					ry[i+1][k] <= ry[i][k] + (rx[i][k] >>> i);
					rz[i+1][k] <= rz[i][k] - hdr_pkg::atan_tab(i);
				end else begin
					rx[i+1][k] <= rx[i][k] + (ry[i][k] >>> i);
					ry[i+1][k] <= ry[i][k] - (rx[i][k] >>> i);
					rz[i+1][k] <= rz[i][k] + hdr_pkg::atan_tab(i);
				end
			end
		end
	end

	// ---- stage B: clamp, sign
	function automatic logic signed [CW-1:0] clamp1(input logic signed [CW-1:0] v);
		return (v > hdr_pkg::OneQ30) ? hdr_pkg::OneQ30 :
			(v < -hdr_pkg::OneQ30) ? -hdr_pkg::OneQ30 : v;
	endfunction
	logic v_b;
	logic signed [31:0] sa_b, sb_b, c1_b, c2_b;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_b <= 1'b0;
		else v_b <= rv[NS];
	end
	always_ff @(posedge clk) begin
		sa_b <= 32'(clamp1(ry[NS][0]));
		sb_b <= 32'(clamp1(ry[NS][1]));
		c1_b <= 32'(rn[NS][2] ? -clamp1(rx[NS][2]) : clamp1(rx[NS][2]));
		c2_b <= 32'(rn[NS][3] ? -clamp1(rx[NS][3]) : clamp1(rx[NS][3]));
	end

	// ---- stage C: squares and cos product
	logic v_c;
	logic signed [31:0] sa2_c, sb2_c, cc_c;
	logic signed [63:0] m_sa, m_sb, m_cc;
	assign m_sa = 64'(sa_b) * 64'(sa_b);
	assign m_sb = 64'(sb_b) * 64'(sb_b);
	assign m_cc = 64'(c1_b) * 64'(c2_b);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c <= 1'b0;
		else v_c <= v_b;
	end
	always_ff @(posedge clk) begin
		sa2_c <= 32'(m_sa >>> 30);
		sb2_c <= 32'(m_sb >>> 30);
		cc_c <= 32'(m_cc >>> 30);
	end

	// ---- stage D: h
	logic v_d;
	logic [30:0] h_d;
	logic signed [63:0] m_h;
	logic signed [33:0] hs;
	assign m_h = 64'(cc_c) * 64'(sb2_c);
	assign hs = 34'(sa2_c) + 34'(m_h >>> 30);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= 1'b0;
		else v_d <= v_c;
	end
	always_ff @(posedge clk) begin
		h_d <= hs[33] ? 31'd0 : (hs > 34'sd1073741824) ? 31'd1073741824 : 31'(hs);
	end

	// ---- square roots: 31 pipelined restoring steps on 62-bit radicands
	localparam int RS = 31;
	logic [61:0] na [RS+1], nb [RS+1];
	logic [31:0] qa [RS+1], qb [RS+1];
	logic sv [RS+1];
	always_comb begin
		sv[0] = v_d;
		na[0] = {h_d, 31'd0} >> 1;
		nb[0] = {31'd1073741824 - h_d, 31'd0} >> 1;
		qa[0] = '0;
		qb[0] = '0;
	end
	for (genvar j = 0; j < RS; j++) begin : g_sq
		localparam int SH = 2 * (RS - 1 - j);
		logic [33:0] ta, tb, ra_, rb_;
		assign ra_ = 34'(na[j] >> SH);
		assign rb_ = 34'(nb[j] >> SH);
		assign ta = {qa[j], 2'b01};
		assign tb = {qb[j], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[j+1] <= 1'b0;
			else sv[j+1] <= sv[j];
		end
		always_ff @(posedge clk) begin
			if (ra_ >= ta) begin
				na[j+1] <= na[j] - (62'(ta) << SH);
				qa[j+1] <= {qa[j][30:0], 1'b1};
			end else begin
				na[j+1] <= na[j];
				qa[j+1] <= {qa[j][30:0], 1'b0};
			end
			if (rb_ >= tb) begin
				nb[j+1] <= nb[j] - (62'(tb) << SH);
				qb[j+1] <= {qb[j][30:0], 1'b1};
			end else begin
				nb[j+1] <= nb[j];
				qb[j+1] <= {qb[j][30:0], 1'b0};
			end
		end
	end

	// ---- vectoring CORDIC
	logic signed [CW-1:0] vx [NS+1], vy [NS+1], vz [NS+1];
	logic vv [NS+1];
	always_comb begin
		vv[0] = sv[RS];
		vx[0] = CW'(qb[RS]);
		vy[0] = CW'(qa[RS]);
		vz[0] = '0;
	end
	for (genvar i = 0; i < NS; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv[i+1] <= 1'b0;
			else vv[i+1] <= vv[i];
		end
		always_ff @(posedge clk) begin
			if (vy[i] > 0) begin
				vx[i+1] <= vx[i] + (vy[i] >>> i);
				vy[i+1] <= vy[i] - (vx[i] >>> i);
				vz[i+1] <= vz[i] + hdr_pkg::atan_tab(i);
			end else begin
				vx[i+1] <= vx[i] - (vy[i] >>> i);
				vy[i+1] <= vy[i] + (vx[i] >>> i);
				vz[i+1] <= vz[i] - hdr_pkg::atan_tab(i);
			end
		end
	end

	// ---- stage E: clamp angle, scale and bin compare
	logic v_e, v_f;
	logic [30:0] z_e;
	logic [63:0] dp;
	logic [22:0] d_raw;
	logic [21:0] d_f;
	always_comb begin
		dp = 64'(z_e) * 64'd7912 + 64'd2097152;
		d_raw = ((dp >> 22) > 64'(hdr_pkg::DistMax)) ? hdr_pkg::DistMax : 23'(dp >> 22);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e <= 1'b0;
			v_f <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_e <= vv[NS];
			v_f <= v_e;
			out_valid <= v_f;
		end
	end
	always_ff @(posedge clk) begin
		z_e <= vz[NS][CW-1] ? 31'd0 :
			(vz[NS] > hdr_pkg::HalfPiQ30) ? 31'(hdr_pkg::HalfPiQ30) : 31'(vz[NS]);
		d_f <= 22'(d_raw);
		out_dist <= d_f;
		for (int k = 0; k < hdr_pkg::NumLimits; k++) out_mask[k] <= (d_f <= limits[k]);
	end

	`HDR_ASSERT_IMP(a_dist_max, clk, arst_n, out_valid, out_dist <= 22'(hdr_pkg::DistMax), "dist")
	`HDR_ASSERT_NXT(a_vpipe, clk, arst_n, v_f, out_valid, "valid lost")
	`HDR_ASSERT_IMP(a_hmax, clk, arst_n, v_d, h_d <= 31'd1073741824, "h range")
endmodule
`default_nettype wire

// ===== rtl/core/haversine_distance_radius_bins_unit.sv =====
`default_nettype none
`include "haversine_distance_radius_bins_unit_defines.svh"
// Haversine great-circle distance with six radius bins.
// Input: a point pair (lat/lon, degrees Q16) is taken when start is high and
// busy is low. busy stays low, so one pair per cycle is accepted.
// Output: done pulses for one cycle with distance_miles (Q14.8) and
// within_mask; the receiver cannot stall, so the output never backs up.
// Pipeline: a result passes front reg, queue beat, range reduction, rotation
// CORDIC, clamp and two multiply stages, 31 root steps, vectoring CORDIC,
// angle clamp, scale and compare, in that order. Throughput is one beat per
// cycle, set by the fully pipelined CORDIC and root stages.
// Config: cfg_valid/cfg_ready write radius_limit_a..f at cfg_index 0..5;
// other indexes are dropped. cfg_ready is always high.
// Reset (arst_n low) clears all valid bits and reloads the default
// limits 5, 10, 15, 20, 25, 50 miles. No clearing pass is needed.
// Front registers pairs and forms angles; a short queue decouples it from
// the back pipeline, which drains one beat per cycle.
module haversine_distance_radius_bins_unit #(
	parameter int CORDIC_STAGES = hdr_pkg::CordicStagesDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic signed [23:0] origin_latitude,
	input  wire logic signed [24:0] origin_longitude,
	input  wire logic signed [23:0] target_latitude,
	input  wire logic signed [24:0] target_longitude,
	output logic done,
	output logic [21:0] distance_miles,
	output logic [5:0] within_mask,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [21:0] cfg_data
);
	localparam int QW = $bits(hdr_pkg::angles_t);
	logic [hdr_pkg::LimW-1:0] limit_q [hdr_pkg::NumLimits];
	logic f_valid, q_empty, q_full;
	hdr_pkg::angles_t f_ang, q_ang;
	hdr_pkg::q_ctl_t qctl;
	logic [QW-1:0] q_rd;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hdr_pkg::NumLimits; k++) limit_q[k] <= hdr_pkg::LimitRst[k];
		end else if (cfg_valid && cfg_ready && (cfg_index < 3'(hdr_pkg::NumLimits))) begin
			limit_q[cfg_index] <= cfg_data;
		end
	end

	hdr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.lat1(origin_latitude), .lon1(origin_longitude),
		.lat2(target_latitude), .lon2(target_longitude),
		.out_valid(f_valid), .out_ang(f_ang)
	);

	// back drains every cycle, so the queue holds at most one beat
	assign qctl.push = f_valid;
	assign qctl.pop = !q_empty;

	hdr_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .ctl(qctl), .wdata(f_ang),
		.rdata(q_rd), .empty(q_empty), .full(q_full)
	);
	assign q_ang = q_rd;

	hdr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(!q_empty), .in_ang(q_ang),
		.limits(limit_q), .out_valid(done), .out_dist(distance_miles),
		.out_mask(within_mask)
	);

	`HDR_ASSERT_IMP(a_q_never_full, clk, arst_n, 1'b1, !q_full, "queue filled")
	`HDR_ASSERT_NXT(a_accept_front, clk, arst_n, start && !busy, f_valid, "front lost beat")
	`HDR_ASSERT_IMP(a_mask_order, clk, arst_n, done && within_mask[0] && (limit_q[0] <= limit_q[1]), within_mask[1], "mask")
endmodule
`default_nettype wire

// ===== test/haversine_distance_radius_bins_checker.sv =====
`default_nettype none
module haversine_distance_radius_bins_checker #(
	parameter int CORDIC_STAGES = hdr_pkg::CordicStagesDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire logic signed [23:0] origin_latitude,
	input  wire logic signed [24:0] origin_longitude,
	input  wire logic signed [23:0] target_latitude,
	input  wire logic signed [24:0] target_longitude,
	input  wire logic done,
	input  wire logic [21:0] distance_miles,
	input  wire logic [5:0] within_mask,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [21:0] cfg_data,
	output int fail_count,
	output int pending
);
	localparam longint FullTurn = 47185920;
	localparam longint HalfTurn = 23592960;
	localparam longint QuarterTurn = 11796480;
	localparam longint DegToRad = 74961321;
	localparam longint StartGain = 652032874;
	localparam longint UnitQ30 = 64'd1 << 30;
	localparam longint RightAngle = 1686629713;
	localparam longint Diameter = 7912;
	localparam longint DistCap = 3181568;

	typedef struct {
		logic [21:0] miles;
		logic [5:0]  mask;
	} dist_beat_t;

	logic [21:0] limits [hdr_pkg::NumLimits];
	dist_beat_t expected_dist [$];

	function automatic longint arctan_step(input int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			default: return (i < 31) ? (64'sd1 <<< (30 - i)) : 64'sd0;
		endcase
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// angle in degrees Q17 -> sine, cosine in Q30
	function automatic void rotate(input longint a, output longint s, output longint c);
		bit flip;
		longint x, y, z, nx;
		flip = 0;
		x = StartGain;
		y = 0;
		a = a % FullTurn;
		if (a > HalfTurn) a -= FullTurn;
		else if (a <= -HalfTurn) a += FullTurn;
		if (a > QuarterTurn) begin
			a = HalfTurn - a;
			flip = 1;
		end else if (a < -QuarterTurn) begin
			a = -HalfTurn - a;
			flip = 1;
		end
		z = (a * DegToRad + 262144) >>> 19;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end
			x = nx;
		end
		x = clip(x, -UnitQ30, UnitQ30);
		s = clip(y, -UnitQ30, UnitQ30);
		c = flip ? -x : x;
	endfunction

	function automatic longint int_root(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vector_angle(input longint a, input longint b);
		longint x, y, z, nx;
		x = b;
		y = a;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end
			x = nx;
		end
		return clip(z, 0, RightAngle);
	endfunction

	function automatic dist_beat_t great_circle(input longint lat1, input longint lon1,
			input longint lat2, input longint lon2);
		longint sa, ca, sb, cb, s1, c1, s2, c2, hv, cc, z, d;
		dist_beat_t r;
		rotate(lat2 - lat1, sa, ca);
		rotate(lon2 - lon1, sb, cb);
		rotate(lat1 * 2, s1, c1);
		rotate(lat2 * 2, s2, c2);
		cc = (c1 * c2) >>> 30;
		hv = clip(((sa * sa) >>> 30) + ((cc * ((sb * sb) >>> 30)) >>> 30), 0, UnitQ30);
		z = vector_angle(int_root(hv << 30), int_root((UnitQ30 - hv) << 30));
		d = (Diameter * z + 2097152) >>> 22;
		if (d > DistCap) d = DistCap;
		r.miles = d[21:0];
		for (int k = 0; k < hdr_pkg::NumLimits; k++)
			r.mask[k] = (d[21:0] <= limits[k]);
		return r;
	endfunction

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		dist_beat_t e;
		if (!arst_n) begin
			for (int k = 0; k < hdr_pkg::NumLimits; k++) limits[k] <= hdr_pkg::LimitRst[k];
			expected_dist.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_dist.size() == 0) begin
					report($sformatf("result %0d/%02h with none due", distance_miles,
						within_mask));
				end else begin
					e = expected_dist.pop_front();
					if (distance_miles !== e.miles)
						report($sformatf("distance %0d, want %0d", distance_miles, e.miles));
					if (within_mask !== e.mask)
						report($sformatf("mask %02h, want %02h", within_mask, e.mask));
				end
			end
			if (start && !busy)
				expected_dist.push_back(great_circle(origin_latitude, origin_longitude,
					target_latitude, target_longitude));
			if (cfg_valid && cfg_ready && cfg_index < hdr_pkg::NumLimits)
				limits[cfg_index] <= cfg_data;
			pending <= expected_dist.size();
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_haversine_distance_radius_bins_unit.sv =====
`default_nettype none
module tb_haversine_distance_radius_bins_unit;
	// register indexes of the config channel
	localparam logic [2:0] RegLimitA = 3'd0;
	localparam logic [2:0] RegLimitF = 3'd5;
	localparam logic [2:0] RegSpare6 = 3'd6;
	localparam logic [2:0] RegSpare7 = 3'd7;

	// angles, degrees Q16
	localparam int Deg90 = 5898240;
	localparam int Deg180 = 11796480;
	localparam int Deg1 = 65536;
	localparam logic [21:0] LimTop = 22'd3181568;

	// leave a margin beyond the pipeline depth when draining
	localparam int DrainCycles = 2 * hdr_pkg::CordicStagesDef + 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [23:0] origin_latitude = '0;
	logic signed [24:0] origin_longitude = '0;
	logic signed [23:0] target_latitude = '0;
	logic signed [24:0] target_longitude = '0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [21:0] cfg_data = '0;
	wire logic busy, done, cfg_ready;
	wire logic [21:0] distance_miles;
	wire logic [5:0] within_mask;
	int fail_count, pending;

	// percent of beats preceded by a sender gap in the current phase
	int gap_pct = 0;

	always #5 clk = ~clk;

	haversine_distance_radius_bins_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_latitude(origin_latitude), .origin_longitude(origin_longitude),
		.target_latitude(target_latitude), .target_longitude(target_longitude),
		.done(done), .distance_miles(distance_miles), .within_mask(within_mask),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// checker sits beside the DUT: predicts, compares, counts
	haversine_distance_radius_bins_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_latitude(origin_latitude), .origin_longitude(origin_longitude),
		.target_latitude(target_latitude), .target_longitude(target_longitude),
		.done(done), .distance_miles(distance_miles), .within_mask(within_mask),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	// one point pair; start stays high across back-to-back beats,
	// and this task drops it only when a gap is actually inserted
	task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		origin_latitude <= lat1[23:0];
		origin_longitude <= lon1[24:0];
		target_latitude <= lat2[23:0];
		target_longitude <= lon2[24:0];
		do @(posedge clk); while (busy);
	endtask

	// valid stays high across back-to-back writes; the caller drops it
	task automatic write_limit(input logic [2:0] idx, input logic [21:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// block is idle only once every expected beat is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// limit mode: 0 all zero, 1 all ones, 2 near-field, 3 full range, 4 mixed extremes
	task automatic load_limits(input int mode);
		logic [21:0] v;
		for (int k = RegLimitA; k <= RegLimitF; k++) begin
			case (mode)
				0: v = '0;
				1: v = '1;
				2: v = 22'($urandom_range(0, 20000));
				3: v = 22'($urandom_range(0, LimTop));
				default: v = (k % 2) ? LimTop : 22'($urandom_range(0, 3000));
			endcase
			write_limit(3'(k), v);
		end
		// writes to unused indexes must be dropped
		write_limit(RegSpare6, 22'($urandom));
		write_limit(RegSpare7, 22'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// mostly near-neighbor pairs so the bins split; some global and raw-bit noise
	task automatic random_pair();
		int lat1, lon1, lat2, lon2, pick;
		pick = $urandom_range(99);
		lat1 = $urandom_range(0, 2 * Deg90) - Deg90;
		lon1 = $urandom_range(0, 2 * Deg180) - Deg180;
		if (pick < 50) begin
			lat2 = lat1 + $urandom_range(0, 2 * Deg1) - Deg1;
			lon2 = lon1 + $urandom_range(0, 2 * Deg1) - Deg1;
		end else if (pick < 85) begin
			lat2 = $urandom_range(0, 2 * Deg90) - Deg90;
			lon2 = $urandom_range(0, 2 * Deg180) - Deg180;
		end else begin
			lat1 = $urandom;
			lon1 = $urandom;
			lat2 = $urandom;
			lon2 = $urandom;
		end
		send_pair(lat1, lon1, lat2, lon2);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats against the reset limits, no gaps
		send_pair(0, 0, 0, 0);
		send_pair(Deg90, Deg180, Deg90, Deg180);
		send_pair(0, 0, 0, Deg180);                   // antipodal on the equator
		send_pair(Deg90, 0, -Deg90, 0);                // pole to pole
		send_pair(-Deg90, -Deg180, Deg90, Deg180);
		send_pair(0, -Deg180, 0, Deg180);              // same meridian, wrapped
		send_pair(0, 0, 4700, 0);                      // around 5 miles
		send_pair(0, 0, 9400, 0);
		send_pair(0, 0, 0, 14100);
		send_pair(Deg90 / 2, 0, Deg90 / 2, 26000);
		send_pair(0, 0, 47000, 0);                     // around 50 miles
		send_pair(-8388608, -16777216, 8388607, 16777215); // field extremes
		send_pair(8388607, 16777215, -8388608, -16777216);
		send_pair(8388607, 0, 0, 0);                   // latitude past 90 degrees
		send_pair(Deg90 + Deg1, 0, Deg90 - Deg1, 0);
		send_pair(0, 16777215, 0, -16777216);          // longitude past 180
		send_pair(-1, -1, 1, 1);
		send_pair(Deg180 / 4, Deg180 / 2, -Deg180 / 4, -Deg180 / 2);
		drain();

		// random phases, each with its own limits and sender gap rate
		for (int ph = 0; ph < 5; ph++) begin
			load_limits(ph);
			case (ph)
				0: gap_pct = 72;
				1: gap_pct = 22;
				2: gap_pct = 0;
				3: gap_pct = 72;
				default: gap_pct = 22;
			endcase
			for (int n = 0; n < 380; n++) begin
				// brief stretches with no gaps inside gapped phases
				if (ph != 2 && n % 100 == 50) gap_pct = 0;
				if (ph != 2 && n % 100 == 80) gap_pct = (ph % 2) ? 22 : 72;
				random_pair();
			end
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hdr_pkg.sv
rtl/core/hdr_front.sv
rtl/core/hdr_queue.sv
rtl/core/hdr_back.sv
rtl/core/haversine_distance_radius_bins_unit.sv
test/haversine_distance_radius_bins_checker.sv
test/tb_haversine_distance_radius_bins_unit.sv
